/* src/proximity_contact_detector_core_macros.svh */
// Assertion helpers used by the detector back end (pcd_back).
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PROXIMITY_CONTACT_DETECTOR_CORE_MACROS_SVH
`define PROXIMITY_CONTACT_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define PCD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcd assertion failed");

// Next-cycle implication.
`define PCD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcd assertion failed");

`endif

/* src/pcd_pkg.sv */
package pcd_pkg;

  // Field widths of the request and result items.
  localparam int unsigned IdxW  = 6;
  localparam int unsigned TimeW = 16;
  localparam int unsigned PosW  = 16;
  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned SqW   = 2 * PosW;
  localparam int unsigned RadW  = 33;

  // Default agent store size.
  localparam int unsigned MaxAgentsDefault = 64;

  // Configuration port.
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 4;
  localparam logic [RadW-1:0] RadiusReset = RadW'(576);
  localparam logic RegRadiusSel = 1'b0;

  // Queue depths. The scan issues a compare only with enough result room
  // for every compare in flight, the held pair and the new one.
  localparam int unsigned CmdDepth   = 2;
  localparam int unsigned ResDepth   = 8;
  localparam int unsigned ResCntW    = $clog2(ResDepth + 1);
  localparam int unsigned CreditNeed = 5;

  typedef struct packed {
    logic                    frame_start;
    logic [IdxW-1:0]         agent_index;
    logic [TimeW-1:0]        time_step;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  first_agent;
    logic [IdxW-1:0]  second_agent;
    logic [TimeW-1:0] contact_time;
    logic             last_of_run;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                    frame_start;
    logic                    in_range;
    logic                    present;
    logic [IdxW-1:0]         agent_index;
    logic [TimeW-1:0]        time_step;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
  } cmd_t;

  // Result write from the back into the result queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackScan,
    BackDrain,
    BackFinish
  } back_state_e;

endpackage

/* src/pcd_front.sv */
module pcd_front import pcd_pkg::*; #(
  parameter int unsigned MaxAgents = MaxAgentsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  cmd_t            cls;
  logic            do_push;
  logic            do_pop;

  // Classify the request: index within the store, and presence.
  always_comb begin
    cls.frame_start = in_data_i.frame_start;
    cls.in_range    = 32'(in_data_i.agent_index) < MaxAgents;
    cls.present     = (in_data_i.pos_x != '0) && (in_data_i.pos_y != '0);
    cls.agent_index = in_data_i.agent_index;
    cls.time_step   = in_data_i.time_step;
    cls.pos_x       = in_data_i.pos_x;
    cls.pos_y       = in_data_i.pos_y;
  end

  assign full        = (count_q == CntW'(CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

/* src/pcd_res_fifo.sv */
module pcd_res_fifo import pcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  res_push_t          res_push_i,
  output logic [ResCntW-1:0] free_o,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_data_o
);

  localparam int unsigned PtrW = $clog2(ResDepth);

  out_item_t          mem_q [ResDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               do_pop;

  assign empty      = (count_q == '0);
  assign free_o     = ResCntW'(ResDepth) - count_q;
  assign out_data_o = mem_q[rd_ptr_q];
  assign do_pop     = pop && !empty;

  // Pointer and fill bookkeeping; the writer never pushes into a full queue.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (res_push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(ResDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(ResDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (res_push_i.valid && !do_pop) begin
      count_d = count_q + ResCntW'(1);
    end else if (!res_push_i.valid && do_pop) begin
      count_d = count_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i.valid) begin
      mem_q[wr_ptr_q] <= res_push_i.item;
    end
  end

endmodule

/* src/pcd_back.sv */
`include "proximity_contact_detector_core_macros.svh"

module pcd_back import pcd_pkg::*; #(
  parameter int unsigned MaxAgents = MaxAgentsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RadW-1:0]    radius_i,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic [ResCntW-1:0] out_free_i,
  output res_push_t          res_push_o
);

  // Only indices that fit the agent index field can ever be stored.
  localparam int unsigned Depth = (MaxAgents < (2 ** IdxW)) ? MaxAgents : (2 ** IdxW);
  localparam int unsigned AddrW = $clog2(Depth);

  back_state_e state_q, state_d;
  cmd_t        cur_q;

  logic [PosW-1:0]  ram_x [Depth];
  logic [PosW-1:0]  ram_y [Depth];
  logic [Depth-1:0] mark_q;

  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] idx_addr;
  logic [AddrW-1:0] idx_last;

  logic                    s1_v_q;
  logic [AddrW-1:0]        s1_k_q;
  logic [PosW-1:0]         rd_x_q, rd_y_q;
  logic                    s2_v_q;
  logic [AddrW-1:0]        s2_k_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic                    s3_v_q;
  logic [AddrW-1:0]        s3_k_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic signed [2*DiffW-1:0] px, py;

  logic             pend_v_q, pend_v_d;
  logic [AddrW-1:0] pend_k_q, pend_k_d;

  logic            issue;
  logic            last_issue;
  logic            fin_ok;
  logic            pipe_empty;
  logic [RadW-1:0] dist_sq;
  logic            hit;

  assign idx_addr   = cur_q.agent_index[AddrW-1:0];
  assign idx_last   = idx_addr - AddrW'(1);
  assign pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;
  assign last_issue = issue && (k_q == idx_last);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (cmd_valid_i) begin
          if (!cmd_i.in_range) begin
            state_d = BackIdle;
          end else if (cmd_i.present && (cmd_i.agent_index != '0)) begin
            state_d = BackScan;
          end else begin
            state_d = BackFinish;
          end
        end
      end
      BackScan: begin
        if (last_issue) begin
          state_d = BackDrain;
        end
      end
      BackDrain: begin
        if (pipe_empty) begin
          state_d = BackFinish;
        end
      end
      BackFinish: begin
        if (fin_ok) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  // Sequencer outputs. A compare is issued only with room for every
  // result that can still come out before the queue drains.
  always_comb begin
    cmd_pop_o = 1'b0;
    issue     = 1'b0;
    fin_ok    = 1'b0;
    case (state_q)
      BackIdle:   cmd_pop_o = cmd_valid_i;
      BackScan:   issue = (out_free_i >= ResCntW'(CreditNeed));
      BackDrain:  ;
      BackFinish: fin_ok = !pend_v_q || (out_free_i != '0);
      default:    ;
    endcase
  end

  // Scan counter.
  always_comb begin
    k_d = k_q;
    if (cmd_pop_o) begin
      k_d = '0;
    end else if (issue) begin
      k_d = k_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BackIdle;
      k_q      <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      s1_v_q   <= issue && mark_q[k_q];
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      pend_v_q <= pend_v_d;
    end
  end

  // Present marks: a frame start clears them all before its request runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (cmd_pop_o && cmd_i.frame_start) begin
      mark_q <= '0;
    end else if (fin_ok) begin
      mark_q[idx_addr] <= cur_q.present;
    end
  end

  // Current request.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // Position store, written when a request finishes, read during the scan.
  always_ff @(posedge clk_i) begin
    if (fin_ok) begin
      ram_x[idx_addr] <= cur_q.pos_x;
      ram_y[idx_addr] <= cur_q.pos_y;
    end
    rd_x_q <= ram_x[k_q];
    rd_y_q <= ram_y[k_q];
  end

  // Distance pipeline: read, difference, square, then sum and compare.
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    s1_k_q <= k_q;
    s2_k_q <= s1_k_q;
    s3_k_q <= s2_k_q;
    dx_q   <= {cur_q.pos_x[PosW-1], cur_q.pos_x} - {rd_x_q[PosW-1], rd_x_q};
    dy_q   <= {cur_q.pos_y[PosW-1], cur_q.pos_y} - {rd_y_q[PosW-1], rd_y_q};
    sqx_q  <= px[SqW-1:0];
    sqy_q  <= py[SqW-1:0];
  end

  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit     = s3_v_q && (dist_sq < radius_i);

  // One contact is held back so that the final one can carry the last mark.
  always_comb begin
    pend_v_d = pend_v_q;
    pend_k_d = pend_k_q;
    if (hit) begin
      pend_v_d = 1'b1;
      pend_k_d = s3_k_q;
    end else if (fin_ok) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_k_q <= pend_k_d;
  end

  always_comb begin
    res_push_o.valid             = pend_v_q && (hit || (fin_ok && (state_q == BackFinish)));
    res_push_o.item.first_agent  = IdxW'(pend_k_q);
    res_push_o.item.second_agent = cur_q.agent_index;
    res_push_o.item.contact_time = cur_q.time_step;
    res_push_o.item.last_of_run  = (state_q == BackFinish);
  end

  `PCD_ASSERT_IMP(a_push_has_room, res_push_o.valid, out_free_i != '0)
  `PCD_ASSERT_IMP(a_issue_below_index, issue, k_q < idx_addr)
  `PCD_ASSERT_IMP(a_finish_pipe_empty, state_q == BackFinish, pipe_empty)
  `PCD_ASSERT_NXT(a_frame_clears_marks, cmd_pop_o && cmd_i.frame_start, mark_q == '0)

endmodule

/* src/proximity_contact_detector_core.sv */
// Proximity contact detector.
// Input channel: each request carries one agent position (index, time step,
// x and y in signed Q11.4). It is taken when push is high and full is low.
// A request with frame_start set clears all present marks first. An agent
// is present only when both coordinates are nonzero.
// Result channel: one entry per agent pair closer than the configured
// radius, lower index first, the final pair of a request marked last. The
// head is shown while empty is low and is taken with pop.
// Scan: a present agent with index n scans the n lower entries of the
// position memory, one per cycle while the result queue has room, through
// a three-stage distance pipeline. Each contact is held until the next one
// is found or the scan ends.
// Two requests queue ahead of the scan, and up to eight results queue
// behind it. When the receiver stalls, the scan pauses once the result
// queue is nearly full, and push backs up through full.
// Reset clears all present marks at once and sets the radius to 1.5 units;
// no clearing pass is needed. radius_squared is at byte address 0.
module proximity_contact_detector_core import pcd_pkg::*; #(
  parameter int unsigned MaxAgents = MaxAgentsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_data_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [RadW-1:0]    radius_q;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic [ResCntW-1:0] out_free;
  res_push_t          res_push;
  logic               reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[3] == RegRadiusSel);
  assign prdata  = reg_sel ? ApbDataW'(radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      radius_q <= pwdata[RadW-1:0];
    end
  end

  pcd_front #(
    .MaxAgents (MaxAgents)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pcd_back #(
    .MaxAgents (MaxAgents)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_free_i  (out_free),
    .res_push_o  (res_push)
  );

  pcd_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .free_o     (out_free),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule
